@@ rtl/kisv_pkg.sv @@
// ----------------------------------------------------------------------------
// kisv_pkg
// Shared types, constants and the byte-wide CRC step for the image checker.
// ----------------------------------------------------------------------------
package kisv_pkg;

  localparam int unsigned SECTOR_BYTES_DFLT    = 512;
  localparam int unsigned MAX_IMAGE_BYTES_DFLT = 33554432;

  localparam int unsigned SLOT_W   = 16;
  localparam int unsigned LEN_W    = 25;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic [SLOT_W-1:0] SLOT_SECTORS_RST = 16'd24576;

  // "KRNL" gathered little-endian
  localparam logic [WORD_W-1:0] MAGIC_LE = 32'h4C4E524B;
  localparam logic [WORD_W-1:0] CRC_POLY = 32'h04C10DB7;
  localparam int unsigned       HDR_TRL_BYTES = 12;
  localparam int unsigned       CRC_BITS      = 8;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_MAGIC = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_LEN   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CRC   = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    payload_length;
    logic [WORD_W-1:0]   computed_crc;
  } kisv_res_t;

  // MSB-first CRC over one byte, unrolled
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc_in,
                                                 input logic [7:0] b);
    logic [WORD_W-1:0] c;
    c = crc_in ^ {b, 24'd0};
    for (int k = 0; k < CRC_BITS; k++) begin
      c = c[WORD_W-1] ? ({c[WORD_W-2:0], 1'b0} ^ CRC_POLY) : {c[WORD_W-2:0], 1'b0};
    end
    return c;
  endfunction

  // clamp a header length to the result field
  function automatic logic [LEN_W-1:0] sat_len(input logic [WORD_W-1:0] len);
    return (|len[WORD_W-1:LEN_W]) ? {LEN_W{1'b1}} : len[LEN_W-1:0];
  endfunction

endpackage

@@ rtl/kisv_in_if.sv @@
// ----------------------------------------------------------------------------
// kisv_in_if
// Byte channel into the image checker: valid/ready with byte and first flag.
// ----------------------------------------------------------------------------
interface kisv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink   (input valid, input data_byte, input first, output ready);
endinterface

@@ rtl/kisv_out_if.sv @@
// ----------------------------------------------------------------------------
// kisv_out_if
// Result channel of the image checker: valid/ready with status, length, CRC.
// ----------------------------------------------------------------------------
interface kisv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [24:0] payload_length;
  logic [31:0] computed_crc;

  modport source (output valid, output status, output payload_length,
                  output computed_crc, input ready);
  modport sink   (input valid, input status, input payload_length,
                  input computed_crc, output ready);
endinterface

@@ rtl/kisv_core.sv @@
// ----------------------------------------------------------------------------
// kisv_core
// Parse state machine: magic, length, payload CRC and trailer, one byte a step.
// ----------------------------------------------------------------------------
module kisv_core
  import kisv_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES    = SECTOR_BYTES_DFLT,
  parameter int unsigned MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DFLT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] slot_sectors,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              first,
  input  logic              res_ready,
  output logic              res_valid,
  output kisv_res_t         res
);

  localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int unsigned SUM_W        = LEN_W + 1;
  localparam logic [WORD_W-1:0] LEN_LIMIT  = WORD_W'(MAX_IMAGE_BYTES - HDR_TRL_BYTES);
  localparam logic [SUM_W-1:0]  ROUND_ADD  = SUM_W'(HDR_TRL_BYTES + SECTOR_BYTES - 1);
  localparam logic [LEN_W-1:0]  LAST_OF_4  = LEN_W'(3);

  typedef enum logic [2:0] {
    PH_IDLE, PH_MAGIC, PH_LENGTH, PH_PAYLOAD, PH_TRAILER
  } phase_t;

  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  byte_position, byte_position_next;
  logic [WORD_W-1:0] length_word, length_word_next;
  logic [WORD_W-1:0] crc_accumulator, crc_accumulator_next;
  logic [WORD_W-1:0] trailer_word, trailer_word_next;
  logic              res_valid_next;
  kisv_res_t         res_next;

  // working copies after the first-flag restart
  phase_t            ph_w;
  logic [LEN_W-1:0]  pos_w, pos_inc;
  logic [WORD_W-1:0] len_w, crc_w, trl_w, len_sh, trl_sh;
  logic [SUM_W-1:0]  round_sum;
  logic [SUM_W-1:0]  sectors_needed;
  logic              len_bad;

  always_comb begin
    ph_w  = first ? PH_MAGIC : phase;
    pos_w = first ? '0 : byte_position;
    len_w = first ? '0 : length_word;
    crc_w = first ? '0 : crc_accumulator;
    trl_w = first ? '0 : trailer_word;

    pos_inc = pos_w + LEN_W'(1);
    len_sh  = {data_byte, len_w[WORD_W-1:8]};
    trl_sh  = {data_byte, trl_w[WORD_W-1:8]};

    round_sum      = {1'b0, len_sh[LEN_W-1:0]} + ROUND_ADD;
    sectors_needed = round_sum >> SECTOR_SHIFT;
    len_bad = (len_sh == '0) || (len_sh > LEN_LIMIT) ||
              (sectors_needed > SUM_W'(slot_sectors));

    phase_next           = ph_w;
    byte_position_next   = pos_w;
    length_word_next     = len_w;
    crc_accumulator_next = crc_w;
    trailer_word_next    = trl_w;
    res_valid_next       = 1'b0;
    res_next             = '{status: STATUS_OK, payload_length: '0, computed_crc: '0};

    unique case (ph_w)
      PH_MAGIC: begin
        trailer_word_next  = trl_sh;
        byte_position_next = pos_inc;
        if (pos_w == LAST_OF_4) begin
          byte_position_next = '0;
          if (trl_sh != MAGIC_LE) begin
            phase_next      = PH_IDLE;
            res_valid_next  = 1'b1;
            res_next.status = STATUS_BAD_MAGIC;
          end else begin
            trailer_word_next = '0;
            phase_next        = PH_LENGTH;
          end
        end
      end
      PH_LENGTH: begin
        length_word_next   = len_sh;
        byte_position_next = pos_inc;
        if (pos_w == LAST_OF_4) begin
          byte_position_next = '0;
          if (len_bad) begin
            phase_next              = PH_IDLE;
            res_valid_next          = 1'b1;
            res_next.status         = STATUS_BAD_LEN;
            res_next.payload_length = sat_len(len_sh);
          end else begin
            crc_accumulator_next = '0;
            phase_next           = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        crc_accumulator_next = crc_byte(crc_w, data_byte);
        byte_position_next   = pos_inc;
        if (WORD_W'(pos_inc) >= len_w) begin
          byte_position_next = '0;
          trailer_word_next  = '0;
          phase_next         = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        trailer_word_next  = trl_sh;
        byte_position_next = pos_inc;
        if (pos_w == LAST_OF_4) begin
          byte_position_next      = '0;
          phase_next              = PH_IDLE;
          res_valid_next          = 1'b1;
          res_next.status         = (trl_sh == crc_w) ? STATUS_OK : STATUS_BAD_CRC;
          res_next.payload_length = sat_len(len_w);
          res_next.computed_crc   = crc_w;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_position   <= '0;
      length_word     <= '0;
      crc_accumulator <= '0;
      trailer_word    <= '0;
      res_valid       <= 1'b0;
    end else begin
      // hold a waiting result until it is taken or replaced by the next step
      if (step) begin
        res_valid <= res_valid_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (step) begin
        phase           <= phase_next;
        byte_position   <= byte_position_next;
        length_word     <= length_word_next;
        crc_accumulator <= crc_accumulator_next;
        trailer_word    <= trailer_word_next;
      end
    end
  end

  // result payload, qualified by res_valid
  always_ff @(posedge clk) begin
    if (step && res_valid_next) begin
      res <= res_next;
    end
  end

endmodule

@@ rtl/kernel_image_stream_verifier.sv @@
// ----------------------------------------------------------------------------
// kernel_image_stream_verifier
// Streaming check of a kernel image: magic, length limits and payload CRC.
// ----------------------------------------------------------------------------
// Usage:
//   din  carries one image byte per item with a first flag that restarts the
//        check; bytes before any first flag or after a result are dropped.
//   dout carries one item per image: at the bad magic, at the rejected length,
//        or on the last trailer byte with status ok or CRC mismatch.
//   cfg_wr_en/cfg_wr_data set slot_sectors; write only while the block idles.
// Timing:
//   A byte sits in the input register, then the parse step writes
//   state and the result register. One byte is accepted every cycle while
//   dout is not stalled with a result waiting; the CRC byte step and the
//   length check are combinational in the parse step.
// Reset clears the parser to idle, empties both registers and loads
//   slot_sectors with 24576. While dout is stalled with a result waiting, the
//   input register still fills once and then din.ready drops until the
//   result is taken.
// ----------------------------------------------------------------------------
module kernel_image_stream_verifier
  import kisv_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES    = SECTOR_BYTES_DFLT,
  parameter int unsigned MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DFLT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SLOT_W-1:0] cfg_wr_data,
  kisv_in_if.sink           din,
  kisv_out_if.source        dout
);

  logic [SLOT_W-1:0] slot_sectors;
  logic              in_valid;
  logic [7:0]        in_byte;
  logic              in_first;
  logic              step;
  logic              res_valid;
  kisv_res_t         res;

  // advance the input register when the parse step can write a result
  assign step      = in_valid && (!res_valid || dout.ready);
  assign din.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_sectors <= SLOT_SECTORS_RST;
      in_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        slot_sectors <= cfg_wr_data;
      end
      if (din.ready) begin
        in_valid <= din.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      in_byte  <= din.data_byte;
      in_first <= din.first;
    end
  end

  kisv_core #(
    .SECTOR_BYTES    (SECTOR_BYTES),
    .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .slot_sectors (slot_sectors),
    .step         (step),
    .data_byte    (in_byte),
    .first        (in_first),
    .res_ready    (dout.ready),
    .res_valid    (res_valid),
    .res          (res)
  );

  // core holds its result until the next step, which waits for dout.ready
  assign dout.valid          = res_valid;
  assign dout.status         = res.status;
  assign dout.payload_length = res.payload_length;
  assign dout.computed_crc   = res.computed_crc;

endmodule
